>>> rtl/core/tepq_pkg.sv
// ----------------------------------------------------------------------------
// Tagged event priority queue package
// Operation and status codes, payload structs and the sequencer state type.
// ----------------------------------------------------------------------------
package tepq_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_POP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  event_id;
    logic [31:0] tag_time;
    logic [15:0] tag_microstep;
    logic [7:0]  tag_level;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_id;
    logic [31:0] out_time;
    logic [15:0] out_microstep;
    logic [7:0]  out_level;
    logic [4:0]  entry_count;
    logic [31:0] least_time;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_MIN,
    S_DONE
  } fsm_t;

endpackage

>>> rtl/core/tagged_event_priority_queue_top.sv
// ----------------------------------------------------------------------------
// Tagged event priority queue top level
// Entries live in one synchronous memory in queue order, head at slot zero.
// A sequencer scans the memory for the position of a sorted insert or remove,
// shifts entries one slot at a time by reading each and writing it one slot
// over, then scans again for the least timestamp. The result stays in an
// output register until taken, and the next transaction is accepted in the
// cycle after that.
// ----------------------------------------------------------------------------
module tagged_event_priority_queue_top
  import tepq_pkg::*;
#(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [31:0]        t;
    logic [15:0]        ms;
    logic [7:0]         lv;
  } ent_t;

  ent_t mem [DEPTH];
  ent_t rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  ent_t          wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  fsm_t state_r, state_nxt;
  in_item_t  req_r, req_nxt;
  out_item_t res_r, res_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          rdv_r, rdv_nxt;
  logic [CW-1:0] rdi_r, rdi_nxt;
  logic [31:0]   min_r, min_nxt;
  ent_t          carry_r, carry_nxt;
  ent_t          new_ent;
  logic          earlier, last_rd;

  assign new_ent.id = ID_BITS'(req_r.event_id);
  assign new_ent.t  = req_r.tag_time;
  assign new_ent.ms = req_r.tag_microstep;
  assign new_ent.lv = req_r.tag_level;

  always_comb begin
    if (new_ent.t != rd_q.t) earlier = new_ent.t < rd_q.t;
    else if (new_ent.ms != rd_q.ms) earlier = new_ent.ms < rd_q.ms;
    else earlier = new_ent.lv < rd_q.lv;
  end

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    rdv_nxt       = 1'b0;
    rdi_nxt       = rdi_r;
    min_nxt       = min_r;
    carry_nxt     = carry_r;
    rd_addr       = idx_r[AW-1:0];
    wr_addr       = pos_r[AW-1:0];
    wr_en         = 1'b0;
    wr_data       = carry_r;
    last_rd       = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          req_nxt = in_data;
          res_nxt = '0;
          idx_nxt = '0;
          pos_nxt = cnt_r;
          if (in_data.op == OP_APPEND || in_data.op == OP_INSERT) begin
            if (cnt_r == CW'(DEPTH)) begin
              res_nxt.status = ST_FULL;
              state_nxt = S_DONE;
            end else if (in_data.op == OP_APPEND || cnt_r == '0) begin
              state_nxt = S_SHIFT;
            end else begin
              state_nxt = S_SCAN;
            end
          end else if (cnt_r == '0) begin
            res_nxt.status = ST_EMPTY;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
          carry_nxt.id = ID_BITS'(in_data.event_id);
          carry_nxt.t  = in_data.tag_time;
          carry_nxt.ms = in_data.tag_microstep;
          carry_nxt.lv = in_data.tag_level;
          if (in_data.op == OP_POP) begin
            pos_nxt = '0;
            idx_nxt = '0;
            state_nxt = (cnt_r == '0) ? S_DONE : S_SHIFT;
          end
        end
      end
      S_SCAN: begin
        rd_addr = idx_r[AW-1:0];
        if (idx_r < cnt_r) begin
          rdv_nxt = 1'b1;
          rdi_nxt = idx_r;
          idx_nxt = idx_r + 1'b1;
        end
        if (rdv_r) begin
          if (req_r.op == OP_INSERT && earlier) begin
            pos_nxt = rdi_r;
            idx_nxt = rdi_r;
            rdv_nxt = 1'b0;
            state_nxt = S_SHIFT;
          end else if (req_r.op == OP_REMOVE && rd_q.id == new_ent.id) begin
            pos_nxt = rdi_r;
            idx_nxt = rdi_r;
            rdv_nxt = 1'b0;
            state_nxt = S_SHIFT;
          end else if (rdi_r + 1'b1 == cnt_r) begin
            rdv_nxt = 1'b0;
            if (req_r.op == OP_INSERT) begin
              pos_nxt = cnt_r;
              state_nxt = S_SHIFT;
            end else begin
              res_nxt.status = ST_NOTFOUND;
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_SHIFT: begin
        // Insert: write carry at pos, carry takes old entry, walk to count.
        // Remove: read pos+1 and write it at pos, first read gives the result.
        if (req_r.op == OP_APPEND || req_r.op == OP_INSERT) begin
          if (!rdv_r) begin
            rd_addr = pos_r[AW-1:0];
            if (pos_r < cnt_r) begin
              rdv_nxt = 1'b1;
            end else begin
              wr_en = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
              idx_nxt = '0;
              min_nxt = '0;
              state_nxt = S_MIN;
            end
          end else begin
            wr_en = 1'b1;
            carry_nxt = rd_q;
            pos_nxt = pos_r + 1'b1;
          end
        end else begin
          if (!rdv_r) begin
            rd_addr = pos_r[AW-1:0];
            rdv_nxt = 1'b1;
            if (pos_r + 1'b1 >= cnt_r) begin
              last_rd = 1'b1;
            end
          end else begin
            if (idx_r == pos_r) begin
              res_nxt.out_id        = 8'(rd_q.id);
              res_nxt.out_time      = rd_q.t;
              res_nxt.out_microstep = rd_q.ms;
              res_nxt.out_level     = rd_q.lv;
            end else begin
              wr_addr = AW'(pos_r - 1'b1);
              wr_data = rd_q;
              wr_en   = 1'b1;
            end
            if (pos_r + 1'b1 >= cnt_r) begin
              cnt_nxt = cnt_r - 1'b1;
              idx_nxt = '0;
              min_nxt = '0;
              state_nxt = S_MIN;
            end else begin
              pos_nxt = pos_r + 1'b1;
            end
          end
        end
        if (last_rd) begin
          idx_nxt = idx_r;
        end
      end
      S_MIN: begin
        rd_addr = idx_r[AW-1:0];
        if (idx_r < cnt_r) begin
          rdv_nxt = 1'b1;
          rdi_nxt = idx_r;
          idx_nxt = idx_r + 1'b1;
        end
        if (rdv_r && (rdi_r == '0 || rd_q.t < min_r)) begin
          min_nxt = rd_q.t;
        end
        if (!rdv_nxt && !(idx_r < cnt_r) && !(rdv_r && idx_r != cnt_r)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        res_nxt.entry_count = 5'(cnt_r);
        res_nxt.least_time  = (rdv_r && (rdi_r == '0 || rd_q.t < min_r)) ? rd_q.t : min_r;
        if (cnt_r == '0) begin
          res_nxt.least_time = '0;
        end
        min_nxt       = res_nxt.least_time;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      rdv_r       <= 1'b0;
      min_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      rdv_r       <= rdv_nxt;
      min_r       <= min_nxt;
    end
    req_r   <= req_nxt;
    res_r   <= res_nxt;
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    rdi_r   <= rdi_nxt;
    carry_r <= carry_nxt;
  end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Tagged event priority queue testbench
// Drives append, sorted insert, remove and pop items with random gaps on both
// handshakes and checks every result against a behavioral queue or typed value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import tepq_pkg::*;

  localparam int QDEPTH = 16;
  localparam int RANDOM_ITEMS = 1100;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] tm;
    logic [15:0] ms;
    logic [7:0]  lv;
  } qent_t;

  typedef struct {
    in_item_t  item;
    logic      known;
    out_item_t result;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  qent_t     queue_model[$];
  out_item_t expected_results[$];
  out_item_t typed_results[$];
  logic      typed_known[$];
  int        error_count = 0;
  int        results_seen = 0;
  int        idle_cycles = 0;
  int        full_seen = 0, empty_seen = 0, notfound_seen = 0;
  bit        stimulus_done = 1'b0;
  bit        hold_off = 1'b0;
  stim_row_t directed[$];

  tagged_event_priority_queue_top #(.DEPTH(QDEPTH), .ID_BITS(8)) dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  function automatic bit tag_earlier(qent_t a, qent_t b);
    if (a.tm != b.tm) return a.tm < b.tm;
    if (a.ms != b.ms) return a.ms < b.ms;
    return a.lv < b.lv;
  endfunction

  function automatic out_item_t apply_queue_op(in_item_t it);
    out_item_t r;
    qent_t e;
    int pos;
    r = '0;
    e = '{id: it.event_id, tm: it.tag_time, ms: it.tag_microstep, lv: it.tag_level};
    if (it.op == OP_APPEND || it.op == OP_INSERT) begin
      if (queue_model.size() >= QDEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = queue_model.size();
        if (it.op == OP_INSERT) begin
          for (pos = 0; pos < queue_model.size(); pos++)
            if (tag_earlier(e, queue_model[pos])) break;
        end
        queue_model.insert(pos, e);
        r.status = ST_OK;
      end
    end else if (queue_model.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      pos = -1;
      if (it.op == OP_POP) pos = 0;
      else begin
        for (int i = 0; i < queue_model.size(); i++)
          if (queue_model[i].id == it.event_id) begin
            pos = i;
            break;
          end
      end
      if (pos < 0) begin
        r.status = ST_NOTFOUND;
      end else begin
        e = queue_model[pos];
        queue_model.delete(pos);
        r.status = ST_OK;
        r.out_id = e.id;
        r.out_time = e.tm;
        r.out_microstep = e.ms;
        r.out_level = e.lv;
      end
    end
    r.entry_count = 5'(queue_model.size());
    r.least_time = '0;
    foreach (queue_model[i])
      if (i == 0 || queue_model[i].tm < r.least_time) r.least_time = queue_model[i].tm;
    return r;
  endfunction

  function automatic in_item_t make_item(op_t op, logic [7:0] id, logic [31:0] tm,
                                         logic [15:0] ms, logic [7:0] lv);
    in_item_t it;
    it.op = op;
    it.event_id = id;
    it.tag_time = tm;
    it.tag_microstep = ms;
    it.tag_level = lv;
    return it;
  endfunction

  task automatic send_item(in_item_t it, logic known, out_item_t typed);
    out_item_t r;
    int gap;
    gap = $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = apply_queue_op(it);
    expected_results.push_back(r);
    typed_known.push_back(known);
    typed_results.push_back(typed);
    if (r.status == ST_FULL) full_seen++;
    if (r.status == ST_EMPTY) empty_seen++;
    if (r.status == ST_NOTFOUND) notfound_seen++;
    @(negedge clk);
  endtask

  function automatic out_item_t typed_result(status_t st, logic [4:0] cnt,
                                             logic [31:0] least);
    out_item_t r;
    r = '0;
    r.status = st;
    r.entry_count = cnt;
    r.least_time = least;
    return r;
  endfunction

  function automatic in_item_t random_item();
    int kind;
    logic [31:0] tm;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: tm = $urandom_range(0, 7);
      1: tm = 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: tm = $urandom;
    endcase
    if (kind < 25)
      return make_item(OP_APPEND, 8'($urandom_range(0, 31)), tm, 16'($urandom),
                       8'($urandom));
    if (kind < 55)
      return make_item(OP_INSERT, 8'($urandom_range(0, 31)), tm, $urandom_range(0, 3) == 0 ?
                       16'(0) : 16'($urandom), $urandom_range(0, 1) ? 8'(0) : 8'($urandom));
    if (kind < 75) begin
      if (queue_model.size() > 0 && $urandom_range(0, 3) != 0)
        return make_item(OP_REMOVE,
                         queue_model[$urandom_range(0, queue_model.size() - 1)].id,
                         $urandom, 16'($urandom), 8'($urandom));
      return make_item(OP_REMOVE, 8'($urandom), $urandom, 16'($urandom), 8'($urandom));
    end
    return make_item(OP_POP, 8'($urandom), $urandom, 16'($urandom), 8'($urandom));
  endfunction

  initial begin
    stim_row_t row;
    out_item_t none;
    none = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed.push_back('{make_item(OP_POP, 8'h00, 32'd0, 16'd0, 8'd0), 1'b1,
                         typed_result(ST_EMPTY, 5'd0, 32'd0)});
    directed.push_back('{make_item(OP_REMOVE, 8'hFF, 32'd0, 16'd0, 8'd0), 1'b1,
                         typed_result(ST_EMPTY, 5'd0, 32'd0)});
    directed.push_back('{make_item(OP_APPEND, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF), 1'b1,
                         typed_result(ST_OK, 5'd1, 32'hFFFF_FFFF)});
    directed.push_back('{make_item(OP_INSERT, 8'h00, 32'd0, 16'd0, 8'd0), 1'b1,
                         typed_result(ST_OK, 5'd2, 32'd0)});
    directed.push_back('{make_item(OP_INSERT, 8'h11, 32'd5, 16'd7, 8'd3), 1'b0, none});
    directed.push_back('{make_item(OP_INSERT, 8'h12, 32'd5, 16'd7, 8'd3), 1'b0, none});
    directed.push_back('{make_item(OP_INSERT, 8'h13, 32'd5, 16'd7, 8'd2), 1'b0, none});
    directed.push_back('{make_item(OP_INSERT, 8'h11, 32'd5, 16'd6, 8'd9), 1'b0, none});
    directed.push_back('{make_item(OP_REMOVE, 8'h11, 32'd0, 16'd0, 8'd0), 1'b0, none});
    directed.push_back('{make_item(OP_REMOVE, 8'h77, 32'd0, 16'd0, 8'd0), 1'b0, none});
    directed.push_back('{make_item(OP_POP, 8'h00, 32'd0, 16'd0, 8'd0), 1'b0, none});
    for (int i = 0; i < 12; i++)
      directed.push_back('{make_item(OP_APPEND, 8'(8'hA0 + i), 32'(100 - i), 16'(i), 8'(i)),
                           1'b0, none});
    directed.push_back('{make_item(OP_INSERT, 8'h55, 32'd1, 16'd1, 8'd1), 1'b1,
                         typed_result(ST_FULL, 5'd16, 32'd5)});
    directed.push_back('{make_item(OP_REMOVE, 8'hFF, 32'd0, 16'd0, 8'd0), 1'b0, none});

    foreach (directed[i]) begin
      row = directed[i];
      send_item(row.item, row.known, row.result);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) hold_off = 1'b1;
      if (i == 340) hold_off = 1'b0;
      send_item(random_item(), 1'b0, none);
    end
    in_valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  initial begin
    int wait_n;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        wait_n = 0;
      end else begin
        wait_n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      end
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    out_item_t exp;
    out_item_t typed;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction %p", out_data);
        error_count++;
      end else begin
        exp = expected_results.pop_front();
        typed = typed_results.pop_front();
        if (typed_known.pop_front()) exp = typed;
        if (out_data.status !== exp.status) begin
          $error("status expected %0d actual %0d", exp.status, out_data.status);
          error_count++;
        end
        if (out_data.out_id !== exp.out_id) begin
          $error("out_id expected %0h actual %0h", exp.out_id, out_data.out_id);
          error_count++;
        end
        if (out_data.out_time !== exp.out_time) begin
          $error("out_time expected %0h actual %0h", exp.out_time, out_data.out_time);
          error_count++;
        end
        if (out_data.out_microstep !== exp.out_microstep) begin
          $error("out_microstep expected %0h actual %0h", exp.out_microstep,
                 out_data.out_microstep);
          error_count++;
        end
        if (out_data.out_level !== exp.out_level) begin
          $error("out_level expected %0h actual %0h", exp.out_level, out_data.out_level);
          error_count++;
        end
        if (out_data.entry_count !== exp.entry_count) begin
          $error("entry_count expected %0d actual %0d", exp.entry_count,
                 out_data.entry_count);
          error_count++;
        end
        if (out_data.least_time !== exp.least_time) begin
          $error("least_time expected %0h actual %0h", exp.least_time,
                 out_data.least_time);
          error_count++;
        end
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    wait (stimulus_done);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Checked %0d results; full %0d, empty %0d, id missing %0d.",
             results_seen, full_seen, empty_seen, notfound_seen);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/tepq_pkg.sv
rtl/core/tagged_event_priority_queue_top.sv
test/tb.sv
